### rtl/rdcc_pkg.sv
package rdcc_pkg;

  localparam int unsigned MAX_ROWS  = 16;
  localparam int unsigned MAX_TERMS = 64;

  localparam int unsigned ROW_W   = 4;
  localparam int unsigned TERM_W  = 6;
  localparam int unsigned RSIZE_W = 5;
  localparam int unsigned TSIZE_W = 7;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned VV_W    = 2 * VAL_W;
  localparam int unsigned PROD_W  = 3 * VAL_W;
  localparam int unsigned G_W     = 54;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned VADDR_W = ROW_W + TERM_W;
  localparam int unsigned V_DEPTH = 1 << VADDR_W;
  localparam int unsigned D_DEPTH = 1 << TERM_W;

  localparam logic [RSIZE_W-1:0] ROWS_RESET  = RSIZE_W'(MAX_ROWS);
  localparam logic [TSIZE_W-1:0] TERMS_RESET = TSIZE_W'(MAX_TERMS);

  typedef enum logic [1:0] {
    CMD_WR_V  = 2'd0,
    CMD_WR_D  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_SIZE_ROWS  = 1'b0,
    CFG_SIZE_TERMS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH,
    S_LOAD
  } state_e;

  typedef struct packed {
    logic accept;
    logic start;
    logic issue;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic q_err;
    logic terms_zero;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/rdcc_ctrl.sv
module rdcc_ctrl
  import rdcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && cmd_i == CMD_QUERY) begin
          cmd_o.start = 1'b1;
          if (status_i.q_err) begin
            state_d = S_LOAD;
          end else if (status_i.terms_zero) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!status_i.pipe_busy) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/rdcc_dp.sv
module rdcc_dp
  import rdcc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_addr_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic [1:0]               cmd_i,
  input  logic [ROW_W-1:0]         row_index_i,
  input  logic [TERM_W-1:0]        term_index_i,
  input  logic [ROW_W-1:0]         col_index_i,
  input  logic signed [VAL_W-1:0]  v_value_i,
  input  logic signed [VAL_W-1:0]  d_real_i,
  input  logic signed [VAL_W-1:0]  d_imag_i,
  input  ctrl_cmd_t                cmd_in_i,
  output dp_status_t               status_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [G_W-1:0]    g_real_o,
  output logic signed [G_W-1:0]    g_imag_o,
  output logic                     index_error_o
);

  logic [RSIZE_W-1:0] size_rows_q;
  logic [TSIZE_W-1:0] size_terms_q;
  logic [RSIZE_W-1:0] rows_eff;
  logic [TSIZE_W-1:0] terms_eff;

  logic [VAL_W-1:0] v_mem  [V_DEPTH];
  logic [VAL_W-1:0] dr_mem [D_DEPTH];
  logic [VAL_W-1:0] di_mem [D_DEPTH];

  logic [ROW_W-1:0]   row_q, col_q;
  logic               err_q;
  logic [TSIZE_W-1:0] k_q;

  logic               s1_v_q, s2_v_q, s3_v_q;
  logic signed [VAL_W-1:0]  va_q, vb_q, dr1_q, di1_q, dr2_q, di2_q;
  logic signed [VV_W-1:0]   vv_q;
  logic signed [PROD_W-1:0] pr_q, pi_q;
  logic signed [G_W-1:0]    acc_re_q, acc_im_q;

  logic out_valid_q;
  logic signed [G_W-1:0] g_real_q, g_imag_q;
  logic                  gerr_q;

  logic wr_v, wr_d, row_ok, col_ok, wterm_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_rows_q  <= ROWS_RESET;
      size_terms_q <= TERMS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_SIZE_ROWS) begin
        size_rows_q <= cfg_wdata_i[RSIZE_W-1:0];
      end else begin
        size_terms_q <= cfg_wdata_i[TSIZE_W-1:0];
      end
    end
  end

  assign rows_eff  = (size_rows_q > ROWS_RESET) ? ROWS_RESET : size_rows_q;
  assign terms_eff = (size_terms_q > TERMS_RESET) ? TERMS_RESET : size_terms_q;

  assign row_ok   = RSIZE_W'(row_index_i) < rows_eff;
  assign col_ok   = RSIZE_W'(col_index_i) < rows_eff;
  assign wterm_ok = TSIZE_W'(term_index_i) < terms_eff;
  assign wr_v     = cmd_in_i.accept && cmd_i == CMD_WR_V && row_ok && wterm_ok;
  assign wr_d     = cmd_in_i.accept && cmd_i == CMD_WR_D && wterm_ok;

  always_ff @(posedge clk_i) begin
    if (wr_v) begin
      v_mem[{row_index_i, term_index_i}] <= v_value_i;
    end
    va_q <= v_mem[{row_q, k_q[TERM_W-1:0]}];
    vb_q <= v_mem[{col_q, k_q[TERM_W-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (wr_d) begin
      dr_mem[term_index_i] <= d_real_i;
      di_mem[term_index_i] <= d_imag_i;
    end
    dr1_q <= dr_mem[k_q[TERM_W-1:0]];
    di1_q <= di_mem[k_q[TERM_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.start) begin
      row_q <= row_index_i;
      col_q <= col_index_i;
      err_q <= !(row_ok && col_ok);
    end
    vv_q  <= va_q * vb_q;
    dr2_q <= dr1_q;
    di2_q <= di1_q;
    pr_q  <= vv_q * dr2_q;
    pi_q  <= vv_q * di2_q;
    if (cmd_in_i.start) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (s3_v_q) begin
      acc_re_q <= acc_re_q + G_W'(pr_q);
      acc_im_q <= acc_im_q + G_W'(pi_q);
    end
    if (cmd_in_i.load) begin
      g_real_q <= acc_re_q;
      g_imag_q <= acc_im_q;
      gerr_q   <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_in_i.start) begin
        k_q <= '0;
      end else if (cmd_in_i.issue) begin
        k_q <= k_q + 1'b1;
      end
      s1_v_q <= cmd_in_i.issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (cmd_in_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.q_err      = !(row_ok && col_ok);
  assign status_o.terms_zero = terms_eff == '0;
  assign status_o.last_issue = (k_q + 1'b1) == terms_eff;
  assign status_o.pipe_busy  = s1_v_q || s2_v_q || s3_v_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign g_real_o      = g_real_q;
  assign g_imag_o      = g_imag_q;
  assign index_error_o = gerr_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_in_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending item");

  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_in_i.load |-> !(s1_v_q || s2_v_q || s3_v_q))
    else $error("result loaded while products in flight");

  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_in_i.issue |-> (k_q < terms_eff))
    else $error("term issued beyond configured size");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_in_i.load))
    else $error("output valid without load");

endmodule

### rtl/real_diag_complex_congruence.sv
// Queries issue one multiply-accumulate per cycle through a three-stage pipeline
// (read/multiply/multiply); an out-of-range query or size_terms of zero skips issue.
// Writes are taken one per cycle, only while idle; no query or write is accepted until
// the last query is loaded, and that load waits while the output register holds an item
// not yet taken. Reset clears control and the size registers (size_rows 16,
// size_terms 64); V and D stores are undefined until written.
module real_diag_complex_congruence
  import rdcc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_addr_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              cmd_i,
  input  logic [ROW_W-1:0]        row_index_i,
  input  logic [TERM_W-1:0]       term_index_i,
  input  logic [ROW_W-1:0]        col_index_i,
  input  logic signed [VAL_W-1:0] v_value_i,
  input  logic signed [VAL_W-1:0] d_real_i,
  input  logic signed [VAL_W-1:0] d_imag_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [G_W-1:0]   g_real_o,
  output logic signed [G_W-1:0]   g_imag_o,
  output logic                    index_error_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  rdcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  rdcc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd_i),
    .row_index_i   (row_index_i),
    .term_index_i  (term_index_i),
    .col_index_i   (col_index_i),
    .v_value_i     (v_value_i),
    .d_real_i      (d_real_i),
    .d_imag_i      (d_imag_i),
    .cmd_in_i      (ctrl_cmd),
    .status_o      (dp_status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .g_real_o      (g_real_o),
    .g_imag_o      (g_imag_o),
    .index_error_o (index_error_o)
  );

endmodule

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdcc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int N_PHASES     = 11;
  localparam int PHASE_ITEMS  = 120;
  localparam int HOLD_PHASE   = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int TAIL_CYCLES  = 80;
  localparam int DIR_N        = 25;

  localparam logic signed [VAL_W-1:0] V_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] V_MAX = 16'sh7FFF;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [ROW_W-1:0]        row;
    logic [TERM_W-1:0]       term;
    logic [ROW_W-1:0]        col;
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] dr;
    logic signed [VAL_W-1:0] di;
  } item_t;

  typedef struct packed {
    logic signed [G_W-1:0] re;
    logic signed [G_W-1:0] im;
    logic                  err;
  } g_res_t;

  typedef struct {
    bit               is_cfg;
    cfg_idx_e         reg_sel;
    logic [CFG_W-1:0] reg_val;
    item_t            it;
    bit               chk;
    logic             err;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic                    cfg_addr_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              cmd_i;
  logic [ROW_W-1:0]        row_index_i;
  logic [TERM_W-1:0]       term_index_i;
  logic [ROW_W-1:0]        col_index_i;
  logic signed [VAL_W-1:0] v_value_i;
  logic signed [VAL_W-1:0] d_real_i;
  logic signed [VAL_W-1:0] d_imag_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [G_W-1:0]   g_real_o;
  logic signed [G_W-1:0]   g_imag_o;
  logic                    index_error_o;

  logic signed [VAL_W-1:0] v_mem    [MAX_ROWS][MAX_TERMS];
  bit                      v_set    [MAX_ROWS][MAX_TERMS];
  logic signed [VAL_W-1:0] d_re_mem [MAX_TERMS];
  logic signed [VAL_W-1:0] d_im_mem [MAX_TERMS];
  bit                      d_set    [MAX_TERMS];
  logic [RSIZE_W-1:0]      rows_reg;
  logic [TSIZE_W-1:0]      terms_reg;

  g_res_t   pending_g[$];
  int       n_mismatch;
  bit       idle_on;
  bit       hold_out;
  dir_row_t dir_tab [DIR_N];

  real_diag_complex_congruence dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    n_mismatch++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int unsigned live_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic int unsigned live_terms();
    return (terms_reg > MAX_TERMS) ? MAX_TERMS : int'(terms_reg);
  endfunction

  function automatic void predict_item(input item_t it, output bit has_res,
                                       output bit took, output g_res_t res);
    int unsigned nr;
    int unsigned nt;
    longint      vv;
    longint      acc_re;
    longint      acc_im;
    nr      = live_rows();
    nt      = live_terms();
    has_res = 1'b0;
    took    = 1'b0;
    res     = '0;
    acc_re  = 0;
    acc_im  = 0;
    case (it.cmd)
      CMD_WR_V: begin
        if (it.row < nr && it.term < nt) begin
          v_mem[it.row][it.term] = it.v;
          v_set[it.row][it.term] = 1'b1;
          took = 1'b1;
        end
      end
      CMD_WR_D: begin
        if (it.term < nt) begin
          d_re_mem[it.term] = it.dr;
          d_im_mem[it.term] = it.di;
          d_set[it.term]    = 1'b1;
          took = 1'b1;
        end
      end
      CMD_QUERY: begin
        has_res = 1'b1;
        took    = 1'b1;
        if (it.row >= nr || it.col >= nr) begin
          res.err = 1'b1;
        end else begin
          for (int k = 0; k < nt; k++) begin
            vv     = longint'(v_mem[it.row][k]) * longint'(v_mem[it.col][k]);
            acc_re += vv * longint'(d_re_mem[k]);
            acc_im += vv * longint'(d_im_mem[k]);
          end
          res.re = acc_re[G_W-1:0];
          res.im = acc_im[G_W-1:0];
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_val();
    case ($urandom_range(0, 9))
      0:       return V_MIN;
      1:       return V_MAX;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_below(input int unsigned n, input int unsigned full);
    return (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, full - 1);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.cmd  = 2'($urandom);
    it.row  = ROW_W'($urandom);
    it.term = TERM_W'($urandom);
    it.col  = ROW_W'($urandom);
    it.v    = pick_val();
    it.dr   = pick_val();
    it.di   = pick_val();
    return it;
  endfunction

  function automatic dir_row_t drow_cfg(input cfg_idx_e sel, input logic [CFG_W-1:0] val);
    dir_row_t r;
    r         = '{default: 0, reg_sel: sel};
    r.is_cfg  = 1'b1;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t drow_item(input logic [1:0] cmd, input int row, input int term,
                                         input int col, input int v, input int dr, input int di,
                                         input bit chk, input logic err);
    dir_row_t r;
    r         = '{default: 0, reg_sel: CFG_SIZE_ROWS};
    r.it.cmd  = cmd;
    r.it.row  = ROW_W'(row);
    r.it.term = TERM_W'(term);
    r.it.col  = ROW_W'(col);
    r.it.v    = VAL_W'(v);
    r.it.dr   = VAL_W'(dr);
    r.it.di   = VAL_W'(di);
    r.chk     = chk;
    r.err     = err;
    return r;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input g_res_t typed_res,
                           output bit took);
    g_res_t res;
    bit     has_res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= it.cmd;
    row_index_i  <= it.row;
    term_index_i <= it.term;
    col_index_i  <= it.col;
    v_value_i    <= it.v;
    d_real_i     <= it.dr;
    d_imag_i     <= it.di;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_item(it, has_res, took, res);
    if (has_res) pending_g.push_back(typed ? typed_res : res);
  endtask

  task automatic send_plain(input item_t it, output bit took);
    send_item(it, 1'b0, '0, took);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_g.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e sel, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= sel;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_SIZE_ROWS) rows_reg = val[RSIZE_W-1:0];
    else terms_reg = val[TSIZE_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic query_seq(inout int cnt);
    item_t            it;
    bit               took;
    int unsigned      nr;
    int unsigned      nt;
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    nr = live_rows();
    nt = live_terms();
    a  = ($urandom_range(0, 6) != 0) ? ROW_W'(pick_below(nr, MAX_ROWS)) : ROW_W'($urandom);
    b  = ($urandom_range(0, 6) != 0) ? ROW_W'(pick_below(nr, MAX_ROWS)) : ROW_W'($urandom);
    if (a < nr && b < nr) begin
      for (int k = 0; k < nt; k++) begin
        if (!v_set[a][k]) begin
          it      = rand_item();
          it.cmd  = CMD_WR_V;
          it.row  = a;
          it.term = TERM_W'(k);
          send_plain(it, took);
          cnt++;
        end
        if (!v_set[b][k]) begin
          it      = rand_item();
          it.cmd  = CMD_WR_V;
          it.row  = b;
          it.term = TERM_W'(k);
          send_plain(it, took);
          cnt++;
        end
        if (!d_set[k]) begin
          it      = rand_item();
          it.cmd  = CMD_WR_D;
          it.term = TERM_W'(k);
          send_plain(it, took);
          cnt++;
        end
      end
    end
    it     = rand_item();
    it.cmd = CMD_QUERY;
    it.row = a;
    it.col = b;
    send_plain(it, took);
    cnt++;
  endtask

  task automatic random_step(inout int cnt);
    item_t       it;
    bit          took;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      query_seq(cnt);
    end else begin
      it = rand_item();
      if (r < 65) begin
        it.cmd = CMD_WR_V;
        if ($urandom_range(0, 9) < 7) begin
          it.row  = ROW_W'(pick_below(live_rows(), MAX_ROWS));
          it.term = TERM_W'(pick_below(live_terms(), MAX_TERMS));
        end
      end else if (r < 82) begin
        it.cmd = CMD_WR_D;
        if ($urandom_range(0, 9) < 7) it.term = TERM_W'(pick_below(live_terms(), MAX_TERMS));
      end else if (r < 90) begin
        it.cmd = CMD_UNUSED;
      end else begin
        it.cmd = CMD_WR_V;
      end
      send_plain(it, took);
      cnt++;
    end
  endtask

  always @(posedge clk_i) begin : check_out
    g_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_g.size() == 0) begin
        flag_mismatch("result with nothing pending");
      end else begin
        want = pending_g.pop_front();
        if (g_real_o !== want.re)
          flag_mismatch($sformatf("g_real got %0d want %0d", g_real_o, want.re));
        if (g_imag_o !== want.im)
          flag_mismatch($sformatf("g_imag got %0d want %0d", g_imag_o, want.im));
        if (index_error_o !== want.err)
          flag_mismatch($sformatf("index_error got %b want %b", index_error_o, want.err));
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int               cnt;
    logic [CFG_W-1:0] rv;
    logic [CFG_W-1:0] tv;
    bit               took;
    g_res_t           typed_res;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_WR_V;
    row_index_i  = '0;
    term_index_i = '0;
    col_index_i  = '0;
    v_value_i    = '0;
    d_real_i     = '0;
    d_imag_i     = '0;
    n_mismatch   = 0;
    idle_on      = 1'b0;
    hold_out     = 1'b0;
    rows_reg     = ROWS_RESET;
    terms_reg    = TERMS_RESET;

    dir_tab = '{
      drow_cfg(CFG_SIZE_ROWS, 7'd2),
      drow_cfg(CFG_SIZE_TERMS, 7'd2),
      drow_item(CMD_WR_V, 0, 0, 0, V_MIN, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_WR_V, 0, 1, 0, V_MAX, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_WR_V, 1, 0, 0, V_MAX, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_WR_V, 1, 1, 0, V_MIN, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_WR_D, 0, 0, 0, 0, V_MIN, V_MAX, 1'b0, 1'b0),
      drow_item(CMD_WR_D, 0, 1, 0, 0, V_MAX, V_MIN, 1'b0, 1'b0),
      drow_item(CMD_WR_V, 2, 0, 0, 1, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_WR_V, 0, 2, 0, 1, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_WR_D, 0, 2, 0, 0, 5, -5, 1'b0, 1'b0),
      drow_item(CMD_UNUSED, 1, 1, 1, 3, 3, 3, 1'b0, 1'b0),
      drow_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_QUERY, 0, 0, 1, 0, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_QUERY, 1, 0, 1, 0, 0, 0, 1'b0, 1'b0),
      drow_item(CMD_QUERY, 2, 0, 0, 0, 0, 0, 1'b1, 1'b1),
      drow_item(CMD_QUERY, 0, 0, 15, 0, 0, 0, 1'b1, 1'b1),
      drow_cfg(CFG_SIZE_ROWS, 7'd0),
      drow_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1),
      drow_cfg(CFG_SIZE_ROWS, 7'h7F),
      drow_cfg(CFG_SIZE_TERMS, 7'd0),
      drow_item(CMD_QUERY, 15, 0, 15, 0, 0, 0, 1'b1, 1'b0),
      drow_item(CMD_WR_D, 0, 0, 0, 0, 1, 1, 1'b0, 1'b0),
      drow_cfg(CFG_SIZE_TERMS, 7'd2),
      drow_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        write_cfg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
      end else begin
        typed_res     = '0;
        typed_res.err = dir_tab[i].err;
        send_item(dir_tab[i].it, dir_tab[i].chk, typed_res, took);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          rv = 7'd0;
          tv = 7'd5;
        end
        1: begin
          rv = 7'd4;
          tv = 7'd0;
        end
        2: begin
          rv = 7'd1;
          tv = 7'd1;
        end
        3: begin
          rv = 7'd16;
          tv = 7'd64;
        end
        4: begin
          rv = 7'h7F;
          tv = 7'd127;
        end
        default: begin
          rv = {2'($urandom), 5'($urandom_range(1, 8))};
          tv = 7'($urandom_range(1, 16));
        end
      endcase
      write_cfg(CFG_SIZE_ROWS, rv);
      write_cfg(CFG_SIZE_TERMS, tv);
      idle_on = (p != N_PHASES - 1) && (p != 2);
      if (p == HOLD_PHASE) hold_out = 1'b1;
      cnt = 0;
      while (cnt < PHASE_ITEMS) random_step(cnt);
    end

    in_valid_i <= 1'b0;
    while (pending_g.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
